/* rtl/sgdm_pkg.sv */
// Shared types, register codes and fixed-point helpers for the SGD momentum
// weight update block. No dependencies; every other rtl file refers to it by scope.
package sgdm_pkg;

  localparam int DATA_W            = 32;
  localparam int FACT_W            = 32;
  localparam int ELEM_ADDR_W       = 16;
  localparam int PADDR_W           = 5;
  localparam int REG_IDX_W         = 3;
  localparam int HISTORY_DEPTH_DEF = 65536;
  localparam int OUT_BUF_DEPTH     = 16;

  // data-by-factor product, rounded product, widened sum
  localparam int PROD_W = DATA_W + FACT_W + 1;
  localparam int RND_W  = PROD_W - 24;
  localparam int SUM_W  = RND_W + 1;

  localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY_FACTOR    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REG_MODE        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_SCALE      = 3'd4;

  localparam logic MODE_L2 = 1'b0;
  localparam logic MODE_L1 = 1'b1;

  localparam logic [FACT_W-1:0] GRAD_SCALE_ONE = 32'h0100_0000;

  typedef struct packed {
    logic [FACT_W-1:0] learning_rate;
    logic [FACT_W-1:0] momentum_factor;
    logic [FACT_W-1:0] decay_factor;
    logic              regularization_mode;
    logic [FACT_W-1:0] grad_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] grad;
    logic                     flag;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_weight;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } sat_t;

  // signed Q16.16 times unsigned Q8.24, exact
  function automatic logic signed [PROD_W-1:0] mul_df(input logic signed [DATA_W-1:0] d,
                                                      input logic [FACT_W-1:0] f);
    logic signed [PROD_W-1:0] de;
    logic signed [PROD_W-1:0] fe;
    de = PROD_W'(d);
    fe = PROD_W'($signed({1'b0, f}));
    mul_df = de * fe;
  endfunction

  // back to Q16.16, half rounds up
  function automatic logic signed [RND_W-1:0] rnd_q24(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    y = x + (PROD_W'(1) <<< 23);
    rnd_q24 = RND_W'(y >>> 24);
  endfunction

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] x);
    sat_t r;
    if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1) begin
      r.value = x[DATA_W-1:0];
      r.clip  = 1'b0;
    end else if (x[SUM_W-1]) begin
      r.value = {1'b1, {(DATA_W-1){1'b0}}};
      r.clip  = 1'b1;
    end else begin
      r.value = {1'b0, {(DATA_W-1){1'b1}}};
      r.clip  = 1'b1;
    end
    sat32 = r;
  endfunction

endpackage

/* rtl/sgdm_cfg.sv */
// APB-style register file for the factors and regularization mode.
// Uses sgdm_pkg for the register codes and the cfg_t bundle.
module sgdm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgdm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output sgdm_pkg::cfg_t                 cfg
);

  logic                              wr_en;
  logic [sgdm_pkg::REG_IDX_W-1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[sgdm_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate       <= '0;
      cfg.momentum_factor     <= '0;
      cfg.decay_factor        <= '0;
      cfg.regularization_mode <= sgdm_pkg::MODE_L2;
      cfg.grad_scale          <= sgdm_pkg::GRAD_SCALE_ONE;
    end else if (wr_en) begin
      unique case (idx)
        sgdm_pkg::REG_LEARNING_RATE:   cfg.learning_rate       <= pwdata;
        sgdm_pkg::REG_MOMENTUM_FACTOR: cfg.momentum_factor     <= pwdata;
        sgdm_pkg::REG_DECAY_FACTOR:    cfg.decay_factor        <= pwdata;
        sgdm_pkg::REG_REG_MODE:        cfg.regularization_mode <= pwdata[0];
        sgdm_pkg::REG_GRAD_SCALE:      cfg.grad_scale          <= pwdata;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sgdm_pkg::REG_LEARNING_RATE:   prdata = cfg.learning_rate;
      sgdm_pkg::REG_MOMENTUM_FACTOR: prdata = cfg.momentum_factor;
      sgdm_pkg::REG_DECAY_FACTOR:    prdata = cfg.decay_factor;
      sgdm_pkg::REG_REG_MODE:        prdata = {31'd0, cfg.regularization_mode};
      sgdm_pkg::REG_GRAD_SCALE:      prdata = cfg.grad_scale;
      default:                       prdata = '0;
    endcase
  end

endmodule

/* rtl/sgdm_front.sv */
// Front pipeline (four stages, stalls as one): reduces the element address to a
// history index and forms the scaled, regularized gradient. Uses sgdm_pkg helpers.
module sgdm_front #(
  parameter int HISTORY_DEPTH = sgdm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sgdm_pkg::cfg_t                          cfg,
  input  logic                                    stall,
  input  logic                                    accept,
  input  logic [sgdm_pkg::ELEM_ADDR_W-1:0]        element_address,
  input  logic signed [sgdm_pkg::DATA_W-1:0]      weight_value,
  input  logic signed [sgdm_pkg::DATA_W-1:0]      gradient_value,
  output logic                                    s4_valid,
  output logic [$clog2(HISTORY_DEPTH)-1:0]        s4_addr,
  output sgdm_pkg::item_t                         s4_item
);

  localparam int  AW    = $clog2(HISTORY_DEPTH);
  localparam int  EAW   = sgdm_pkg::ELEM_ADDR_W;
  localparam int  DW    = sgdm_pkg::DATA_W;
  localparam int  PW    = sgdm_pkg::PROD_W;
  localparam int  RW    = sgdm_pkg::RND_W;
  localparam int  SW    = sgdm_pkg::SUM_W;
  localparam int  FW_SUM = sgdm_pkg::FACT_W + 1;
  localparam bit  SMALL = HISTORY_DEPTH < (1 << EAW);
  localparam bit  POW2  = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;

  logic adv;
  assign adv = !stall;

  // stage 1
  logic                    s1_valid;
  logic [EAW-1:0]          s1_addr;
  logic signed [DW-1:0]    s1_w;
  logic signed [DW-1:0]    s1_g;
  logic signed [PW-1:0]    pg1;
  logic signed [PW-1:0]    pd1;

  // stage 2
  logic                    s2_valid;
  logic [EAW-1:0]          s2_addr;
  logic signed [DW-1:0]    s2_w;
  logic signed [PW-1:0]    s2_pg;
  logic signed [PW-1:0]    s2_pd;
  logic [EAW:0]            rem2;
  sgdm_pkg::sat_t          g1s2;

  // stage 3
  logic                    s3_valid;
  logic [EAW:0]            s3_rem;
  logic signed [DW-1:0]    s3_w;
  logic signed [DW-1:0]    s3_g1;
  logic                    s3_f;
  logic signed [RW-1:0]    s3_tl2;
  logic [AW-1:0]           addr3;
  logic [FW_SUM-1:0]       dsum3;
  logic signed [RW-1:0]    t3;
  sgdm_pkg::sat_t          g2s3;
  sgdm_pkg::item_t         item3;

  assign pg1 = sgdm_pkg::mul_df(s1_g, cfg.grad_scale);
  assign pd1 = sgdm_pkg::mul_df(s1_w, cfg.decay_factor);

  assign g1s2 = sgdm_pkg::sat32(SW'(sgdm_pkg::rnd_q24(s2_pg)));

  // address reduction: reciprocal estimate, one multiply-subtract, one correction
  if (SMALL && !POW2) begin : g_mod
    localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(HISTORY_DEPTH));
    localparam logic [EAW:0]  DMOD  = (EAW+1)'(HISTORY_DEPTH);
    logic [EAW+31:0]          qp1;
    logic [EAW-1:0]           s2_q;
    logic [2*EAW+1:0]         qd2;

    assign qp1 = {32'd0, s1_addr} * {{EAW{1'b0}}, RECIP};
    always_ff @(posedge clk) begin
      if (adv) s2_q <= qp1[EAW+31:32];
    end
    assign qd2   = {1'b0, s2_q} * DMOD;
    assign rem2  = {1'b0, s2_addr} - qd2[EAW:0];
    assign addr3 = (s3_rem >= DMOD) ? AW'(s3_rem - DMOD) : AW'(s3_rem);
  end else begin : g_plain
    assign rem2  = {1'b0, s2_addr};
    assign addr3 = AW'(s3_rem);
  end

  // L1 magnitude: rnd(decay * 2^16) = (decay + 2^7) >> 8
  assign dsum3 = {1'b0, cfg.decay_factor} + FW_SUM'(128);

  always_comb begin
    if (cfg.regularization_mode == sgdm_pkg::MODE_L1) begin
      if (s3_w > 0)      t3 = RW'({1'b0, dsum3[FW_SUM-1:8]});
      else if (s3_w < 0) t3 = -RW'({1'b0, dsum3[FW_SUM-1:8]});
      else               t3 = '0;
    end else begin
      t3 = s3_tl2;
    end
  end

  assign g2s3 = sgdm_pkg::sat32(SW'(s3_g1) + SW'(t3));

  always_comb begin
    item3.weight = s3_w;
    if (cfg.decay_factor != '0) begin
      item3.grad = g2s3.value;
      item3.flag = s3_f | g2s3.clip;
    end else begin
      item3.grad = s3_g1;
      item3.flag = s3_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_addr <= element_address;
        s1_w    <= weight_value;
        s1_g    <= gradient_value;
      end
      s2_addr <= s1_addr;
      s2_w    <= s1_w;
      s2_pg   <= pg1;
      s2_pd   <= pd1;
      s3_rem  <= rem2;
      s3_w    <= s2_w;
      s3_g1   <= g1s2.value;
      s3_f    <= g1s2.clip;
      s3_tl2  <= sgdm_pkg::rnd_q24(s2_pd);
      s4_addr <= addr3;
      s4_item <= item3;
    end
  end

endmodule

/* rtl/sgdm_rmw.sv */
// History memory with its clearing sweep and the read-modify-write stages:
// read, multiply, add and write back, final weight. Uses sgdm_pkg helpers.
module sgdm_rmw #(
  parameter int HISTORY_DEPTH = sgdm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sgdm_pkg::cfg_t                      cfg,
  input  logic                                s4_valid,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]    s4_addr,
  input  sgdm_pkg::item_t                     s4_item,
  output logic                                stall,
  output logic                                clearing,
  output logic                                res_valid,
  output sgdm_pkg::result_t                   res
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int DW = sgdm_pkg::DATA_W;
  localparam int PW = sgdm_pkg::PROD_W;
  localparam int SW = sgdm_pkg::SUM_W;
  localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

  logic [DW-1:0]          mem [HISTORY_DEPTH];
  logic signed [DW-1:0]   rdata;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DW-1:0]          mem_wdata;
  logic [AW-1:0]          clr_addr;

  logic                   s5_valid;
  logic [AW-1:0]          s5_addr;
  sgdm_pkg::item_t        s5_item;
  logic signed [DW-1:0]   h_old5;
  logic                   fwd5;

  logic                   s6_valid;
  logic [AW-1:0]          s6_addr;
  logic signed [DW-1:0]   s6_w;
  logic                   s6_f;
  logic signed [PW-1:0]   s6_pl;
  logic signed [PW-1:0]   s6_pm;
  sgdm_pkg::sat_t         h6;

  logic                   s7_valid;
  logic [AW-1:0]          s7_addr;
  logic signed [DW-1:0]   s7_w;
  logic                   s7_f;
  logic signed [DW-1:0]   s7_h;
  sgdm_pkg::sat_t         nw7;

  // back-to-back hit on one entry: hold the front while the earlier item is in s5
  assign stall = s4_valid & s5_valid & (s4_addr == s5_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) clearing <= 1'b0;
    end
  end

  assign mem_we    = clearing | s6_valid;
  assign mem_waddr = clearing ? clr_addr : s6_addr;
  assign mem_wdata = clearing ? '0 : h6.value;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[s4_addr];
  end

  // an entry written two stages ahead lands after this read was taken
  assign fwd5   = s7_valid & (s7_addr == s5_addr);
  assign h_old5 = fwd5 ? s7_h : rdata;

  assign h6  = sgdm_pkg::sat32(SW'(sgdm_pkg::rnd_q24(s6_pl)) + SW'(sgdm_pkg::rnd_q24(s6_pm)));
  assign nw7 = sgdm_pkg::sat32(SW'(s7_w) - SW'(s7_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid & !stall;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_addr <= s4_addr;
    s5_item <= s4_item;
    s6_addr <= s5_addr;
    s6_w    <= s5_item.weight;
    s6_f    <= s5_item.flag;
    s6_pl   <= sgdm_pkg::mul_df(s5_item.grad, cfg.learning_rate);
    s6_pm   <= sgdm_pkg::mul_df(h_old5, cfg.momentum_factor);
    s7_addr <= s6_addr;
    s7_w    <= s6_w;
    s7_f    <= s6_f | h6.clip;
    s7_h    <= h6.value;
  end

  assign res_valid      = s7_valid;
  assign res.new_weight = nw7.value;
  assign res.saturated  = s7_f | nw7.clip;

endmodule

/* rtl/sgdm_out_buf.sv */
// Result buffer and credit counter: the pipeline never waits on the result side, so
// input is taken only while every item in flight has a slot waiting. Uses sgdm_pkg::result_t.
module sgdm_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic                 push,
  input  sgdm_pkg::result_t    push_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output sgdm_pkg::result_t    out_data,
  output logic                 credit_ok
);

  localparam int DEPTH = sgdm_pkg::OUT_BUF_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  sgdm_pkg::result_t  buf_mem [DEPTH];
  logic [PTR_W:0]     wr_ptr;
  logic [PTR_W:0]     rd_ptr;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;
  logic               out_accept;

  assign out_valid  = wr_ptr != rd_ptr;
  assign out_data   = buf_mem[rd_ptr[PTR_W-1:0]];
  assign out_accept = out_valid & out_ready;
  assign credit_ok  = occ != OCC_W'(DEPTH);

  always_comb begin
    unique case ({in_accept, out_accept})
      2'b10:   occ_next = occ + 1'b1;
      2'b01:   occ_next = occ - 1'b1;
      default: occ_next = occ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push)       wr_ptr <= wr_ptr + 1'b1;
      if (out_accept) rd_ptr <= rd_ptr + 1'b1;
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_mem[wr_ptr[PTR_W-1:0]] <= push_data;
  end

endmodule

/* rtl/sgd_momentum_weight_update.sv */
// Top level of the SGD momentum weight update: config registers, front pipeline,
// history read-modify-write and result buffer. Needs sgdm_pkg and the sgdm_* modules.
//
//   port group    | dir | beat / handshake
//   --------------+-----+-------------------------------------------------------
//   apb config    | in  | psel/penable/pwrite, written on access cycle, pready=1
//   input item    | in  | in_valid/in_ready: element_address, weight, gradient
//   result item   | out | out_valid/out_ready: new_weight, saturated
//
// One item per cycle sustained unless a same-entry hold, the sweep or a full buffer
// stops input. Two consecutive items hitting the same history entry hold the front
// while the first is in s5, set by the momentum multiply and the history add sitting
// in separate stages of the loop. After reset the history memory is swept to zero with
// in_ready low. Up to 16 results queue when out_ready is low; input then stops.
module sgd_momentum_weight_update #(
  parameter int HISTORY_DEPTH = sgdm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgdm_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sgdm_pkg::ELEM_ADDR_W-1:0]    element_address,
  input  logic signed [sgdm_pkg::DATA_W-1:0]  weight_value,
  input  logic signed [sgdm_pkg::DATA_W-1:0]  gradient_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sgdm_pkg::DATA_W-1:0]  new_weight,
  output logic                                saturated
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  sgdm_pkg::cfg_t     cfg;
  logic               accept;
  logic               stall;
  logic               clearing;
  logic               credit_ok;
  logic               s4_valid;
  logic [AW-1:0]      s4_addr;
  sgdm_pkg::item_t    s4_item;
  logic               res_valid;
  sgdm_pkg::result_t  res;
  sgdm_pkg::result_t  out_data;

  assign in_ready   = !clearing & !stall & credit_ok;
  assign accept     = in_valid & in_ready;
  assign new_weight = out_data.new_weight;
  assign saturated  = out_data.saturated;

  sgdm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgdm_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .stall           (stall),
    .accept          (accept),
    .element_address (element_address),
    .weight_value    (weight_value),
    .gradient_value  (gradient_value),
    .s4_valid        (s4_valid),
    .s4_addr         (s4_addr),
    .s4_item         (s4_item)
  );

  sgdm_rmw #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_rmw (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s4_valid  (s4_valid),
    .s4_addr   (s4_addr),
    .s4_item   (s4_item),
    .stall     (stall),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  sgdm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_accept (accept),
    .push      (res_valid),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .credit_ok (credit_ok)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stall |-> !in_ready)
    else $error("input taken while the front pipeline is held");

  a_single_bubble: assert property (@(posedge clk) disable iff (rst)
    stall |=> !stall)
    else $error("same-entry hold lasted more than one cycle");

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!res_valid && !out_valid && !s4_valid))
    else $error("item activity during the history clearing sweep");

endmodule
